/* src/f2i_pkg.sv */
package f2i_pkg;

   localparam int VALUE_W = 64;

   typedef enum logic [1:0] {
      OP_U32 = 2'd0,
      OP_S32 = 2'd1,
      OP_U64 = 2'd2,
      OP_S64 = 2'd3
   } op_type;

   localparam logic [31:0] S_U32_HI = 32'h4f800000;
   localparam logic [31:0] S_S32_HI = 32'h4f000000;
   localparam logic [31:0] S_U64_HI = 32'h5f800000;
   localparam logic [31:0] S_S64_HI = 32'h5f000000;
   localparam logic [31:0] S_NEG_ONE = 32'hbf800000;
   localparam logic [31:0] S_S32_LO = 32'hcf000000;
   localparam logic [31:0] S_S64_LO = 32'hdf000000;
   localparam logic [31:0] S_SIGN = 32'h80000000;

   localparam logic [63:0] D_U32_HI = 64'h41efffffffe00000;
   localparam logic [63:0] D_S32_HI = 64'h41dfffffffc00000;
   localparam logic [63:0] D_S32_LO = 64'hc1e0000000000000;
   localparam logic [63:0] D_NEG_ONE = 64'hbfefffffffffffff;
   localparam logic [63:0] D_U64_HI = 64'h43f0000000000000;
   localparam logic [63:0] D_S64_HI = 64'h43e0000000000000;
   localparam logic [63:0] D_S64_LO = 64'hc3e0000000000000;
   localparam logic [63:0] D_SIGN = 64'h8000000000000000;

   // Decoded operand, passed from the decode stage to the shift stage.
   typedef struct packed {
      logic        neg;
      logic        nan;
      logic        inf;
      logic        big;
      logic        two64;
      logic        small_frac;
      logic [10:0] expo;
      logic [52:0] sig;
      op_type      op;
      logic        safe;
   } dec_type;

   // Magnitude stage result.
   typedef struct packed {
      logic        neg;
      logic        nan;
      logic        inf;
      logic        big;
      logic        two64;
      logic        frac;
      logic [63:0] mag;
      op_type      op;
      logic        safe;
   } mag_type;

endpackage

/* src/f2i_decode.sv */
module f2i_decode
   import f2i_pkg::*;
(
   input  logic [63:0] value_bits,
   input  logic        is_single,
   input  logic [1:0]  operation,
   output dec_type     dec
);

   logic [63:0] bits;
   logic [31:0] u;
   logic [7:0]  se;
   logic [22:0] sm;
   logic [4:0]  p;
   logic [51:0] wm;
   logic [10:0] ex;
   logic [51:0] m;
   logic        s32;
   logic        s64;
   op_type      op;

   always_comb begin
      u = value_bits[31:0];
      se = u[30:23];
      sm = u[22:0];
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (sm[i]) begin
            p = 5'(i);
         end
      end
      wm = {sm, 29'd0} << (6'd23 - {1'b0, p});
      if (se == 8'hff) begin
         bits = {u[31], 11'h7ff, sm, 29'd0};
      end else if (se != 8'd0) begin
         bits = {u[31], 11'({3'd0, se} + 11'd896), sm, 29'd0};
      end else if (sm == 23'd0) begin
         bits = {u[31], 63'd0};
      end else begin
         bits = {u[31], 11'({6'd0, p} + 11'd874), wm};
      end
      if (!is_single) begin
         bits = value_bits;
      end
   end

   assign op = op_type'(operation);
   assign ex = bits[62:52];
   assign m = bits[51:0];

   always_comb begin
      unique case (op)
         OP_U32: s32 = u < S_U32_HI || (u >= S_SIGN && u < S_NEG_ONE);
         OP_S32: s32 = u < S_S32_HI || (u >= S_SIGN && u <= S_S32_LO);
         OP_U64: s32 = u < S_U64_HI || (u >= S_SIGN && u < S_NEG_ONE);
         default: s32 = u < S_S64_HI || (u >= S_SIGN && u <= S_S64_LO);
      endcase
      unique case (op)
         OP_U32: s64 = value_bits <= D_U32_HI ||
                       (value_bits >= D_SIGN && value_bits <= D_NEG_ONE);
         OP_S32: s64 = value_bits <= D_S32_HI ||
                       (value_bits >= D_SIGN && value_bits <= D_S32_LO);
         OP_U64: s64 = value_bits < D_U64_HI ||
                       (value_bits >= D_SIGN && value_bits <= D_NEG_ONE);
         default: s64 = value_bits < D_S64_HI ||
                        (value_bits >= D_SIGN && value_bits <= D_S64_LO);
      endcase
   end

   always_comb begin
      dec.neg = bits[63];
      dec.nan = (ex == 11'h7ff) && (m != 52'd0);
      dec.inf = (ex == 11'h7ff) && (m == 52'd0);
      dec.big = (ex == 11'h7ff) || (ex >= 11'd1087);
      dec.two64 = (ex == 11'd1087) && (m == 52'd0);
      dec.small_frac = (ex < 11'd1023) && ((ex != 11'd0) || (m != 52'd0));
      dec.expo = ex;
      dec.sig = {1'b1, m};
      dec.op = op;
      dec.safe = is_single ? s32 : s64;
   end

endmodule

/* src/f2i_shift.sv */
module f2i_shift
   import f2i_pkg::*;
(
   input  dec_type dec,
   output mag_type mg
);

   logic [116:0] wide;
   logic [5:0]   e;
   logic         in_win;

   // The significand sits with its point after bit 52 of a 117-bit window.
   always_comb begin
      in_win = (dec.expo >= 11'd1023) && (dec.expo < 11'd1087);
      e = dec.expo[5:0] - 6'd63;
      wide = {64'd0, dec.sig} << e;
      mg.neg = dec.neg;
      mg.nan = dec.nan;
      mg.inf = dec.inf;
      mg.big = dec.big;
      mg.two64 = dec.two64;
      mg.frac = in_win ? (wide[51:0] != 52'd0) : dec.small_frac;
      mg.mag = in_win ? wide[115:52] : 64'd0;
      mg.op = dec.op;
      mg.safe = dec.safe;
   end

endmodule

/* src/f2i_saturate.sv */
module f2i_saturate
   import f2i_pkg::*;
(
   input  mag_type     mg,
   output logic [63:0] int_result,
   output logic        exact_in_range
);

   logic        sgn;
   logic        wide;
   logic [63:0] max;
   logic [63:0] lim;
   logic        ovf;
   logic        ex;

   always_comb begin
      sgn = mg.op[0];
      wide = mg.op[1];
      max = wide ? 64'hffffffffffffffff : 64'h00000000ffffffff;
      lim = wide ? 64'h8000000000000000 : 64'h0000000080000000;
      ovf = mg.nan || mg.big;
      if (!sgn) begin
         if (mg.neg) begin
            int_result = 64'd0;
         end else if (ovf || mg.mag > max) begin
            int_result = max;
         end else begin
            int_result = mg.mag;
         end
         ex = wide ? (!mg.neg && (!mg.big || mg.two64))
                   : (!mg.neg && !mg.big && mg.mag <= max);
      end else begin
         if (mg.neg) begin
            int_result = (ovf || mg.mag >= lim) ? (64'd0 - lim) : (64'd0 - mg.mag);
         end else begin
            int_result = (ovf || mg.mag >= lim) ? (lim - 64'd1) : mg.mag;
         end
         ex = wide ? (!mg.big && mg.mag <= lim)
                   : (!mg.big && (mg.neg ? mg.mag <= lim : mg.mag <= lim - 64'd1));
      end
      exact_in_range = ex && !mg.nan && !mg.inf && !mg.frac;
   end

endmodule

/* src/float_to_int_saturating_convert_unit.sv */
// Channel | Direction | tdata fields (low bit up)               | tuser
// req     | in        | value_bits[63:0]                         | is_single, operation[1:0]
// rsp     | out       | int_result[63:0]                         | exact_in_range, trunc_safe
//
// Three register stages (decode, shift, saturate).
// One transaction per cycle is accepted unless a stall at rsp backs up to req. Each stage
// advances when empty or when the next advances; a bubble fills whenever a stage is empty.
// Synchronous reset clears the valid bits only.
module float_to_int_saturating_convert_unit
   import f2i_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value_bits
   input  logic [2:0]  req_tuser,  // is_single, operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // int_result
   output logic [1:0]  rsp_tuser   // exact_in_range, trunc_safe
);

   dec_type     dec_in, dec_ff;
   mag_type     mag_in, mag_ff;
   logic [63:0] res_in, res_ff;
   logic        ex_in, ex_ff, safe_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic        adv3, adv2, adv1;

   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   f2i_decode u_dec (
      .value_bits(req_tdata),
      .is_single (req_tuser[0]),
      .operation (req_tuser[2:1]),
      .dec       (dec_in)
   );

   f2i_shift u_shift (
      .dec(dec_ff),
      .mg (mag_in)
   );

   f2i_saturate u_sat (
      .mg            (mag_ff),
      .int_result    (res_in),
      .exact_in_range(ex_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) dec_ff <= dec_in;
      if (adv2) mag_ff <= mag_in;
      if (adv3) begin
         res_ff <= res_in;
         ex_ff <= ex_in;
         safe_ff <= mag_ff.safe;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata = res_ff;
   assign rsp_tuser = {safe_ff, ex_ff};

endmodule

/* dv/tb_float_to_int_saturating_convert_unit.sv */
`timescale 1ns / 1ps

module tb_float_to_int_saturating_convert_unit;
   import f2i_pkg::*;

   localparam int  NUM_RANDOM  = 1030;
   localparam int  CYCLE_LIMIT = 200000;
   localparam int  DRAIN       = 12;

   typedef struct {
      logic [63:0] value;
      logic        single;
      op_type      op;
      bit          typed;
      logic [63:0] want_int;
      logic        want_exact;
      logic        want_safe;
   } row_type;

   typedef struct {
      logic [63:0] int_val;
      logic        exact;
      logic        safe;
   } conv_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;  // is_single, operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // int_result
   logic [1:0]  rsp_tuser;        // exact_in_range, trunc_safe

   conv_type conv_queue[$];
   row_type  directed[$];
   int    error_count = 0;
   int    cycle_count = 0;
   int    sent_count = 0;
   int    checked_count = 0;
   int    stall_left = 0;
   bit    quiet = 1'b0;

   float_to_int_saturating_convert_unit DUT (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_float_to_int_saturating_convert_unit: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] widen_to_double(logic [31:0] f);
      logic [63:0] s;
      logic [7:0]  e;
      logic [63:0] m;
      int          p;
      s = {f[31], 63'd0};
      e = f[30:23];
      m = {41'd0, f[22:0]};
      if (e == 8'hff) return s | (64'h7ff << 52) | (m << 29);
      if (e != 8'd0) return s | ((64'(e) + 64'd896) << 52) | (m << 29);
      if (m == 0) return s;
      p = 22;
      while (m[p] == 1'b0) p--;
      m[p] = 1'b0;
      return s | ((64'(p) + 64'd874) << 52) | (m << (52 - p));
   endfunction

   function automatic conv_type convert(logic [63:0] raw, logic single, op_type op);
      conv_type    r;
      logic [63:0] bits, sig, mag, maxv, lim;
      logic [10:0] ex;
      logic        neg, nan, inf, big, two64, frac, sgn, wide, ex_ok;
      logic [31:0] u;
      int          e, sh;
      bits = single ? widen_to_double(raw[31:0]) : raw;
      ex = bits[62:52];
      neg = bits[63];
      nan = 0; inf = 0; big = 0; two64 = 0; frac = 0; mag = 0;
      if (ex == 11'h7ff) begin
         nan = bits[51:0] != 0;
         inf = bits[51:0] == 0;
         big = 1;
      end else if (ex < 11'd1023) begin
         frac = (ex != 0) || (bits[51:0] != 0);
      end else begin
         e = int'(ex) - 1023;
         sig = {12'd1, bits[51:0]};
         if (e >= 64) begin
            big = 1;
            two64 = (e == 64) && (bits[51:0] == 0);
         end else if (e <= 52) begin
            sh = 52 - e;
            mag = sig >> sh;
            frac = (sig & ((64'd1 << sh) - 64'd1)) != 0;
         end else begin
            mag = sig << (e - 52);
         end
      end
      sgn = op[0];
      wide = op[1];
      if (!sgn) begin
         maxv = wide ? 64'hffff_ffff_ffff_ffff : 64'hffff_ffff;
         if (neg) r.int_val = 0;
         else if (nan || big || mag > maxv) r.int_val = maxv;
         else r.int_val = mag;
         ex_ok = wide ? (!neg && (!big || two64)) : (!neg && !big && mag <= maxv);
      end else begin
         lim = wide ? (64'd1 << 63) : (64'd1 << 31);
         if (neg) r.int_val = (nan || big || mag >= lim) ? 64'd0 - lim : 64'd0 - mag;
         else r.int_val = (nan || big || mag >= lim) ? lim - 64'd1 : mag;
         if (wide) ex_ok = !big && mag <= lim;
         else ex_ok = !big && (neg ? mag <= lim : mag <= lim - 64'd1);
      end
      r.exact = ex_ok && !nan && !inf && !frac;
      if (single) begin
         u = raw[31:0];
         case (op)
            OP_U32: r.safe = u < S_U32_HI || (u >= S_SIGN && u < S_NEG_ONE);
            OP_S32: r.safe = u < S_S32_HI || (u >= S_SIGN && u <= S_S32_LO);
            OP_U64: r.safe = u < S_U64_HI || (u >= S_SIGN && u < S_NEG_ONE);
            default: r.safe = u < S_S64_HI || (u >= S_SIGN && u <= S_S64_LO);
         endcase
      end else begin
         case (op)
            OP_U32: r.safe = raw <= D_U32_HI || (raw >= D_SIGN && raw <= D_NEG_ONE);
            OP_S32: r.safe = raw <= D_S32_HI || (raw >= D_SIGN && raw <= D_S32_LO);
            OP_U64: r.safe = raw < D_U64_HI || (raw >= D_SIGN && raw <= D_NEG_ONE);
            default: r.safe = raw < D_S64_HI || (raw >= D_SIGN && raw <= D_S64_LO);
         endcase
      end
      return r;
   endfunction

   function automatic void add_row(logic [63:0] v, logic s, op_type op, bit typed = 0,
                                   logic [63:0] wi = 0, logic we = 0, logic ws = 0);
      row_type row;
      row.value = v; row.single = s; row.op = op; row.typed = typed;
      row.want_int = wi; row.want_exact = we; row.want_safe = ws;
      directed.push_back(row);
   endfunction

   // Random operand: raw bits, values around the conversion thresholds, or special exponents.
   function automatic logic [63:0] random_value(logic single);
      logic [63:0] bounds[8];
      logic [31:0] sbounds[7];
      logic [63:0] v;
      bounds = '{D_U32_HI, D_S32_HI, D_S32_LO, D_NEG_ONE, D_U64_HI, D_S64_HI,
                 D_S64_LO, 64'h41f0000000000000};
      sbounds = '{S_U32_HI, S_S32_HI, S_U64_HI, S_S64_HI, S_NEG_ONE, S_S32_LO, S_S64_LO};
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: if (single) v[31:0] = sbounds[$urandom_range(0, 6)] + 32'($urandom_range(0, 4))
                                  - 32'd2;
            else v = bounds[$urandom_range(0, 7)] + 64'($urandom_range(0, 4)) - 64'd2;
         2: if (single) v[30:23] = 8'($urandom_range(110, 200));
            else v[62:52] = 11'($urandom_range(1000, 1090));
         default: if (single) v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            else v[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
      endcase
      return v;
   endfunction

   task automatic send(logic [63:0] v, logic s, op_type op);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tuser <= {op, s};
      do @(posedge clock); while (!req_tready);
      conv_queue.push_back(convert(v, s, op));
      sent_count++;
   endtask

   // Result side: random stalls, compare against the oldest expectation.
   always @(posedge clock) begin
      conv_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (conv_queue.size() == 0) begin
               $error("unexpected transaction: int_result %h", rsp_tdata);
               error_count++;
            end else begin
               exp_r = conv_queue.pop_front();
               checked_count++;
               if (rsp_tdata !== exp_r.int_val) begin
                  $error("int_result expected %h actual %h", exp_r.int_val, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser[0] !== exp_r.exact) begin
                  $error("exact_in_range expected %b actual %b", exp_r.exact, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tuser[1] !== exp_r.safe) begin
                  $error("trunc_safe expected %b actual %b", exp_r.safe, rsp_tuser[1]);
                  error_count++;
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 5);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      conv_type got;
      logic     s;
      int       wait_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_row(64'h0, 0, OP_U32, 1, 64'h0, 1, 1);
      add_row(64'h8000000000000000, 0, OP_U32, 1, 64'h0, 0, 1);   // negative zero
      add_row(64'h8000000000000000, 0, OP_S32, 1, 64'h0, 1, 1);
      add_row(64'h7ff0000000000000, 0, OP_U64, 1, 64'hffffffffffffffff, 0, 0);
      add_row(64'hfff0000000000000, 0, OP_S64, 1, 64'h8000000000000000, 0, 0);
      add_row(64'h7ff8000000000000, 0, OP_S32, 1, 64'h7fffffff, 0, 0);
      add_row(64'hfff8000000000000, 0, OP_S32, 1, 64'hffffffff80000000, 0, 0);
      add_row(64'hfff8000000000000, 0, OP_U32, 1, 64'h0, 0, 0);
      add_row(64'h00000000ffc00001, 1, OP_S64);                    // negative single NaN
      add_row(64'h000000007fc00000, 1, OP_U64);
      add_row(64'hffffffff3f800000, 1, OP_U32);                    // junk in upper half
      add_row(64'h41dfffffffe00000, 0, OP_S32);                    // 2147483647.5
      add_row(D_S32_HI, 0, OP_S32);
      add_row(D_S32_LO, 0, OP_S32);
      add_row(D_U32_HI, 0, OP_U32);
      add_row(D_U64_HI, 0, OP_U64);                                // exactly 2^64
      add_row(D_S64_HI, 0, OP_S64);                                // exactly 2^63
      add_row(D_S64_LO, 0, OP_S64);
      add_row(D_NEG_ONE, 0, OP_U64);
      add_row(64'h0000000000000001, 1, OP_S32);                    // single denormal
      add_row(64'h00000000807fffff, 1, OP_S64);
      add_row(64'h7fefffffffffffff, 0, OP_U64);
      add_row(64'hffffffffffffffff, 0, OP_S64);
      add_row({32'h0, S_S64_LO}, 1, OP_S64);

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            got = convert(directed[i].value, directed[i].single, directed[i].op);
            if (got.int_val !== directed[i].want_int || got.exact !== directed[i].want_exact
                || got.safe !== directed[i].want_safe) begin
               $error("table row %0d disagrees with predictor", i);
               error_count++;
            end
         end
         send(directed[i].value, directed[i].single, directed[i].op);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         s = 1'($urandom_range(0, 1));
         send(random_value(s), s, op_type'($urandom_range(0, 3)));
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (conv_queue.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d conversions (%0d directed) over all four targets;", sent_count,
               directed.size());
      $display("checked %0d results, %0d still pending.", checked_count, conv_queue.size());
      if (error_count == 0 && conv_queue.size() == 0) begin
         $display("tb_float_to_int_saturating_convert_unit: done, clean");
      end else begin
         $display("tb_float_to_int_saturating_convert_unit: done, errors");
      end
      $finish;
   end

endmodule
